// ===== rtl/core/scaled_glyph_column_renderer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scaled glyph column renderer
// Clocked, reset-gated property checks used at the end of the back-end module.
// ----------------------------------------------------------------------------
`ifndef SCALED_GLYPH_COLUMN_RENDERER_ASSERT_SVH
`define SCALED_GLYPH_COLUMN_RENDERER_ASSERT_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define SGCR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must never be seen outside reset.
`define SGCR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SGCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SGCR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/core/sgcr_pkg.sv =====
// ----------------------------------------------------------------------------
// sgcr_pkg
// Shared constants, register indexes and types of the glyph column renderer.
// ----------------------------------------------------------------------------
package sgcr_pkg;

  // Defaults of the top-level parameters.
  localparam int SCREEN_W_DEF      = 320;
  localparam int SCREEN_H_DEF      = 200;
  localparam int GLYPH_COLUMNS_DEF = 5;
  localparam int GLYPH_ROWS_DEF    = 8;
  localparam int MAX_SCALE_DEF     = 8;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // Field widths.
  localparam int GLYPH_W  = 40;
  localparam int COORD_W  = 10;  // origin registers and on-screen x (screen up to 1024)
  localparam int SCALE_W  = 4;
  localparam int COLOR_W  = 8;
  localparam int POS_W    = 8;
  localparam int CNT_W    = 7;   // up to 8 columns times scale 8
  localparam int SUB_W    = 3;   // glyph column index and repeat counter
  localparam int MASK_W   = 64;
  localparam int COLX_W   = 9;
  localparam int ROWT_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INK      = 2'd3;

  localparam logic [COORD_W-1:0] ORIGIN_RST = '0;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 4'd1;
  localparam logic [COLOR_W-1:0] INK_RST    = 8'd15;

  // One character that has at least one column to draw.
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [COORD_W-1:0] start_x;
    logic [CNT_W-1:0]   n_cols;
  } col_job_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

// ===== rtl/core/sgcr_front.sv =====
// ----------------------------------------------------------------------------
// sgcr_front
// Accepts characters, tracks the pen position and queues visible glyphs.
// ----------------------------------------------------------------------------
module sgcr_front #(
  parameter int SCREEN_W      = sgcr_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H      = sgcr_pkg::SCREEN_H_DEF,
  parameter int GLYPH_COLUMNS = sgcr_pkg::GLYPH_COLUMNS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             req_take,
  input  logic [sgcr_pkg::GLYPH_W-1:0]     glyph_bits,
  input  logic                             glyph_found,
  input  logic                             string_start,
  input  logic [sgcr_pkg::COORD_W-1:0]     origin_x,
  input  logic [sgcr_pkg::COORD_W-1:0]     origin_y,
  input  logic [sgcr_pkg::SCALE_W-1:0]     eff_scale,
  output logic                             push,
  output sgcr_pkg::col_job_t               job
);

  localparam int XS_W = sgcr_pkg::COORD_W + 1;
  localparam logic [XS_W-1:0] SW_X = XS_W'(SCREEN_W);
  localparam logic [XS_W-1:0] SH_X = XS_W'(SCREEN_H);
  localparam logic [sgcr_pkg::CNT_W-1:0] ADV_MUL  = sgcr_pkg::CNT_W'(GLYPH_COLUMNS + 1);
  localparam logic [sgcr_pkg::CNT_W-1:0] COLS_MUL = sgcr_pkg::CNT_W'(GLYPH_COLUMNS);
  localparam logic [sgcr_pkg::POS_W:0]   POS_SAT  = {1'b0, {sgcr_pkg::POS_W{1'b1}}};

  logic [sgcr_pkg::POS_W-1:0] char_pos_r, char_pos_nxt;
  logic [sgcr_pkg::POS_W-1:0] pos_base;
  logic [sgcr_pkg::CNT_W-1:0] advance;
  logic [sgcr_pkg::CNT_W-1:0] cols;
  logic [sgcr_pkg::POS_W:0]   pos_sum;
  logic [XS_W-1:0]            start_x;
  logic [XS_W-1:0]            room;
  logic                       visible;

  always_comb begin
    pos_base = string_start ? '0 : char_pos_r;
    advance  = sgcr_pkg::CNT_W'(ADV_MUL * sgcr_pkg::CNT_W'(eff_scale));
    cols     = sgcr_pkg::CNT_W'(COLS_MUL * sgcr_pkg::CNT_W'(eff_scale));
    pos_sum  = {1'b0, pos_base} + (sgcr_pkg::POS_W+1)'(advance);
    char_pos_nxt = (pos_sum > POS_SAT) ? POS_SAT[sgcr_pkg::POS_W-1:0]
                                       : pos_sum[sgcr_pkg::POS_W-1:0];
    start_x  = XS_W'(origin_x) + XS_W'(pos_base);
    room     = SW_X - start_x;
    // Columns run left to right, so the visible ones are a prefix.
    visible  = glyph_found && (XS_W'(origin_x) < SW_X) && (XS_W'(origin_y) < SH_X)
               && (start_x < SW_X);
    push     = req_take && visible;
    job.glyph   = glyph_bits;
    job.start_x = start_x[sgcr_pkg::COORD_W-1:0];
    job.n_cols  = (XS_W'(cols) < room) ? cols : room[sgcr_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_pos_r <= '0;
    end else if (req_take) begin
      char_pos_r <= char_pos_nxt;
    end
  end

endmodule

// ===== rtl/core/sgcr_fifo.sv =====
// ----------------------------------------------------------------------------
// sgcr_fifo
// Short first-word-fall-through queue of glyph jobs between front and back.
// ----------------------------------------------------------------------------
module sgcr_fifo #(
  parameter int DEPTH = sgcr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sgcr_pkg::col_job_t push_job,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output sgcr_pkg::col_job_t head_job
);

  // DEPTH must be a power of two of at least two, so the pointers wrap naturally; not checked here.
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sgcr_pkg::col_job_t     entry_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign head_job  = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/core/sgcr_back.sv =====
// ----------------------------------------------------------------------------
// sgcr_back
// Steps through the screen columns of one queued glyph, one column per cycle while the output slot is free.
// ----------------------------------------------------------------------------
`include "scaled_glyph_column_renderer_assert.svh"

module sgcr_back #(
  parameter int SCREEN_W   = sgcr_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H   = sgcr_pkg::SCREEN_H_DEF,
  parameter int GLYPH_ROWS = sgcr_pkg::GLYPH_ROWS_DEF,
  parameter int MAX_SCALE  = sgcr_pkg::MAX_SCALE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  sgcr_pkg::col_job_t            job,
  output logic                          job_pop,
  input  logic [sgcr_pkg::COORD_W-1:0]  origin_y,
  input  logic [sgcr_pkg::SCALE_W-1:0]  eff_scale,
  input  logic [sgcr_pkg::COLOR_W-1:0]  ink_color,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sgcr_pkg::COLX_W-1:0]   out_column_x,
  output logic [sgcr_pkg::ROWT_W-1:0]   out_row_top,
  output logic [sgcr_pkg::MASK_W-1:0]   out_pixel_mask,
  output logic [sgcr_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic                          out_last
);

  localparam int MW   = sgcr_pkg::MASK_W;
  localparam int XS_W = sgcr_pkg::COORD_W + 1;
  localparam logic [XS_W-1:0] SH_X = XS_W'(SCREEN_H);
  localparam logic [XS_W-1:0] SW_X = XS_W'(SCREEN_W);
  localparam logic [sgcr_pkg::CNT_W-1:0] ROWS_MUL = sgcr_pkg::CNT_W'(GLYPH_ROWS);

  sgcr_pkg::back_state_t state_r, state_nxt;

  logic [sgcr_pkg::GLYPH_W-1:0] glyph_r;
  logic [sgcr_pkg::COORD_W-1:0] start_x_r;
  logic [sgcr_pkg::CNT_W-1:0]   n_cols_r;
  logic [sgcr_pkg::CNT_W-1:0]   cx_r, cx_nxt;
  logic [sgcr_pkg::SUB_W-1:0]   px_r, px_nxt;
  logic [sgcr_pkg::SUB_W-1:0]   rep_r, rep_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [sgcr_pkg::COLX_W-1:0]  column_x_r;
  logic [sgcr_pkg::ROWT_W-1:0]  row_top_r;
  logic [MW-1:0]                mask_r;
  logic [sgcr_pkg::COLOR_W-1:0] color_r;
  logic                         last_r;

  logic                         load;
  logic                         emit;
  logic                         slot_free;
  logic                         is_last_col;
  logic [MW-1:0]                glyph_ext;
  logic [7:0]                   gcol;
  logic [MAX_SCALE-1:0][MW-1:0] expand;
  logic [MW-1:0]                scaled;
  logic [MW-1:0]                row_ok;
  logic [sgcr_pkg::CNT_W-1:0]   rows_lim;
  logic [XS_W-1:0]              h_room;
  logic [XS_W-1:0]              col_sum;

  assign slot_free   = !out_valid_r || out_ready;
  assign is_last_col = (cx_r == n_cols_r - sgcr_pkg::CNT_W'(1));
  assign glyph_ext   = MW'(glyph_r);
  assign gcol        = glyph_ext[8*px_r +: 8];
  assign col_sum     = XS_W'(start_x_r) + XS_W'(cx_r);

  // Each scale has its own fixed row replication; the live one is picked below.
  for (genvar s = 1; s <= MAX_SCALE; s++) begin : g_scale
    for (genvar y = 0; y < MW; y++) begin : g_row
      localparam int SRC = y / s;
      if (y < GLYPH_ROWS * s) begin : g_on
        assign expand[s-1][y] = gcol[SRC];
      end else begin : g_off
        assign expand[s-1][y] = 1'b0;
      end
    end
  end

  always_comb begin
    scaled = '0;
    for (int s = 1; s <= MAX_SCALE; s++) begin
      if (eff_scale == sgcr_pkg::SCALE_W'(s)) begin
        scaled = expand[s-1];
      end
    end
  end

  // Rows beyond the scaled glyph height or below the screen bottom are dropped from the mask.
  always_comb begin
    rows_lim = sgcr_pkg::CNT_W'(ROWS_MUL * sgcr_pkg::CNT_W'(eff_scale));
    h_room   = SH_X - XS_W'(origin_y);
    for (int y = 0; y < MW; y++) begin
      row_ok[y] = (sgcr_pkg::CNT_W'(y) < rows_lim) && (XS_W'(y) < h_room);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sgcr_pkg::BK_IDLE: begin
        if (job_valid) begin
          state_nxt = sgcr_pkg::BK_RUN;
        end
      end
      sgcr_pkg::BK_RUN: begin
        if (slot_free && is_last_col) begin
          state_nxt = sgcr_pkg::BK_IDLE;
        end
      end
      default: state_nxt = sgcr_pkg::BK_IDLE;
    endcase
  end

  // Outputs and counter updates.
  always_comb begin
    load    = 1'b0;
    emit    = 1'b0;
    cx_nxt  = cx_r;
    px_nxt  = px_r;
    rep_nxt = rep_r;
    case (state_r)
      sgcr_pkg::BK_IDLE: begin
        load    = job_valid;
        cx_nxt  = '0;
        px_nxt  = '0;
        rep_nxt = '0;
      end
      sgcr_pkg::BK_RUN: begin
        emit = slot_free;
        if (slot_free) begin
          cx_nxt = cx_r + sgcr_pkg::CNT_W'(1);
          if (rep_r == sgcr_pkg::SUB_W'(eff_scale - sgcr_pkg::SCALE_W'(1))) begin
            rep_nxt = '0;
            px_nxt  = px_r + sgcr_pkg::SUB_W'(1);
          end else begin
            rep_nxt = rep_r + sgcr_pkg::SUB_W'(1);
          end
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  assign job_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgcr_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      cx_r        <= '0;
      px_r        <= '0;
      rep_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cx_r        <= cx_nxt;
      px_r        <= px_nxt;
      rep_r       <= rep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      glyph_r   <= job.glyph;
      start_x_r <= job.start_x;
      n_cols_r  <= job.n_cols;
    end
    if (emit) begin
      column_x_r <= col_sum[sgcr_pkg::COLX_W-1:0];
      row_top_r  <= origin_y[sgcr_pkg::ROWT_W-1:0];
      mask_r     <= scaled & row_ok;
      color_r    <= ink_color;
      last_r     <= is_last_col;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_column_x    = column_x_r;
  assign out_row_top     = row_top_r;
  assign out_pixel_mask  = mask_r;
  assign out_pixel_color = color_r;
  assign out_last        = last_r;

  `SGCR_ASSERT(a_cx_in_range, clk, rst_n, (state_r != sgcr_pkg::BK_RUN) || (cx_r < n_cols_r), "column counter ran past the column count")
  `SGCR_ASSERT(a_last_ends_job, clk, rst_n, emit && is_last_col |=> state_r == sgcr_pkg::BK_IDLE, "back end did not finish after the last column")
  `SGCR_ASSERT_NEVER(a_col_off_screen, clk, rst_n, emit && (col_sum >= SW_X), "emitted a column beyond the screen edge")

endmodule

// ===== rtl/core/scaled_glyph_column_renderer.sv =====
// ----------------------------------------------------------------------------
// scaled_glyph_column_renderer
// Renders scaled glyph bitmaps as a stream of screen columns with row masks.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Carries
//  in_     | input     | in_valid/in_ready  | glyph bits, found and start flags
//  out_    | output    | out_valid/out_ready| column x, top row, mask, color, last
//  cfg_    | input     | cfg_we             | origin x/y, scale, ink color
//
// In the back end, a character that draws n on-screen columns is first loaded
// from the queue, then sent one column per cycle while the output slot is free,
// up to GLYPH_COLUMNS * MAX_SCALE columns; the next is loaded after the last.
// Characters that draw nothing advance the pen in the front end only.
// The front end keeps accepting while the QUEUE_DEPTH-entry queue has room, and the
// output register lets the back end finish a column while out_ready is low.
// Reset is synchronous; it clears the pen position and queue and sets the configuration to its defaults.
// ----------------------------------------------------------------------------
module scaled_glyph_column_renderer #(
  parameter int SCREEN_W      = sgcr_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H      = sgcr_pkg::SCREEN_H_DEF,
  parameter int GLYPH_COLUMNS = sgcr_pkg::GLYPH_COLUMNS_DEF,
  parameter int GLYPH_ROWS    = sgcr_pkg::GLYPH_ROWS_DEF,
  parameter int MAX_SCALE     = sgcr_pkg::MAX_SCALE_DEF,
  parameter int QUEUE_DEPTH   = sgcr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sgcr_pkg::GLYPH_W-1:0]     in_glyph_bits,
  input  logic                             in_glyph_found,
  input  logic                             in_string_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sgcr_pkg::COLX_W-1:0]      out_column_x,
  output logic [sgcr_pkg::ROWT_W-1:0]      out_row_top,
  output logic [sgcr_pkg::MASK_W-1:0]      out_pixel_mask,
  output logic [sgcr_pkg::COLOR_W-1:0]     out_pixel_color,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [sgcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sgcr_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  localparam logic [sgcr_pkg::SCALE_W-1:0] SCALE_MAX = sgcr_pkg::SCALE_W'(MAX_SCALE);

  logic [sgcr_pkg::COORD_W-1:0] origin_x_r;
  logic [sgcr_pkg::COORD_W-1:0] origin_y_r;
  logic [sgcr_pkg::SCALE_W-1:0] scale_r;
  logic [sgcr_pkg::COLOR_W-1:0] ink_r;
  logic [sgcr_pkg::SCALE_W-1:0] eff_scale;

  logic               req_take;
  logic               push;
  logic               pop;
  logic               full;
  logic               not_empty;
  sgcr_pkg::col_job_t push_job;
  sgcr_pkg::col_job_t head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= sgcr_pkg::ORIGIN_RST;
      origin_y_r <= sgcr_pkg::ORIGIN_RST;
      scale_r    <= sgcr_pkg::SCALE_RST;
      ink_r      <= sgcr_pkg::INK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sgcr_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_wdata;
        sgcr_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        sgcr_pkg::CFG_SCALE:    scale_r    <= cfg_wdata[sgcr_pkg::SCALE_W-1:0];
        sgcr_pkg::CFG_INK:      ink_r      <= cfg_wdata[sgcr_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // A scale of zero draws at one; anything above the maximum is clamped.
  always_comb begin
    if (scale_r == '0) begin
      eff_scale = sgcr_pkg::SCALE_W'(1);
    end else if (scale_r > SCALE_MAX) begin
      eff_scale = SCALE_MAX;
    end else begin
      eff_scale = scale_r;
    end
  end

  assign in_ready = !full;
  assign req_take = in_valid && in_ready;

  sgcr_front #(
    .SCREEN_W      (SCREEN_W),
    .SCREEN_H      (SCREEN_H),
    .GLYPH_COLUMNS (GLYPH_COLUMNS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_take     (req_take),
    .glyph_bits   (in_glyph_bits),
    .glyph_found  (in_glyph_found),
    .string_start (in_string_start),
    .origin_x     (origin_x_r),
    .origin_y     (origin_y_r),
    .eff_scale    (eff_scale),
    .push         (push),
    .job          (push_job)
  );

  sgcr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head_job  (head_job)
  );

  sgcr_back #(
    .SCREEN_W   (SCREEN_W),
    .SCREEN_H   (SCREEN_H),
    .GLYPH_ROWS (GLYPH_ROWS),
    .MAX_SCALE  (MAX_SCALE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (not_empty),
    .job             (head_job),
    .job_pop         (pop),
    .origin_y        (origin_y_r),
    .eff_scale       (eff_scale),
    .ink_color       (ink_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_column_x    (out_column_x),
    .out_row_top     (out_row_top),
    .out_pixel_mask  (out_pixel_mask),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last)
  );

endmodule
